/* hdl/fpca_pkg.sv */
// ----------------------------------------------------------------------------
// Complex ALU package
// Shared types, operation codes and widths for the fixed-point complex ALU.
// ----------------------------------------------------------------------------
package fpca_pkg;

    // Widths of the datapath
    localparam int OperW = 32;
    localparam int DataW = 64;
    localparam int FracW = 5;
    localparam int MagW  = 16;

    // Fraction bits after reset
    localparam logic [FracW-1:0] FracReset = 5'd15;

    // Operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;

    // Register indexes on the configuration port
    localparam logic REG_FRAC_BITS = 1'b0;

    // One input beat
    typedef struct packed {
        logic [2:0]              operation;
        logic signed [OperW-1:0] a_real;
        logic signed [OperW-1:0] a_imag;
        logic signed [OperW-1:0] b_real;
        logic signed [OperW-1:0] b_imag;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic signed [DataW-1:0] res_real;
        logic signed [DataW-1:0] res_imag;
        logic [MagW-1:0]         magnitude;
    } out_item_t;

endpackage

/* hdl/fpca_div.sv */
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of two 64-bit unsigned values, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fpca_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fpca_pkg::DataW-1:0]  dividend,
    input  logic [fpca_pkg::DataW-1:0]  divisor,
    output logic                        done,
    output logic [fpca_pkg::DataW-1:0]  quotient
);

    localparam int CntW = $clog2(fpca_pkg::DataW);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CntW-1:0]             cnt_reg;
    logic [fpca_pkg::DataW:0]    rem_reg;
    logic [fpca_pkg::DataW-1:0]  quo_reg;
    logic [fpca_pkg::DataW-1:0]  dsr_reg;
    logic [fpca_pkg::DataW:0]    rem_shift;
    logic [fpca_pkg::DataW:0]    rem_diff;
    logic                        fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        rem_shift = {rem_reg[fpca_pkg::DataW-1:0], quo_reg[fpca_pkg::DataW-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
    end

    // Control: count the quotient bits and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(fpca_pkg::DataW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift together
    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff : rem_shift;
            quo_reg <= {quo_reg[fpca_pkg::DataW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/fixed_point_complex_alu_unit.sv */
// ----------------------------------------------------------------------------
// Fixed-point complex ALU
// Add, subtract, multiply and divide of signed complex fixed-point operands,
// and the magnitude of the first operand.
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready until its result beat
// has been taken. Add, subtract and undefined codes go straight to the result
// register. Every real product goes through one shared 32 by 32 multiplier,
// one product a cycle, and is registered before it is accumulated; the square
// root of the magnitude produces one root bit a cycle. Divide runs its products
// and then two passes through the shared 64-bit divider. The result waits in an
// output register for as long as the receiver stalls.
// ----------------------------------------------------------------------------
module fixed_point_complex_alu_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fpca_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fpca_pkg::out_item_t   out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int OW = fpca_pkg::OperW;
    localparam int DW = fpca_pkg::DataW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SQRT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        SRC_AR,
        SRC_AI,
        SRC_BR,
        SRC_BI
    } src_t;

    typedef enum logic [1:0] {
        DST_R,
        DST_I,
        DST_D
    } dst_t;

    // One step of the product schedule
    typedef struct packed {
        src_t x;
        src_t y;
        dst_t dst;
        logic neg;
    } step_t;

    state_t                      state_reg;
    logic [fpca_pkg::FracW-1:0]  frac_reg;
    logic [2:0]                  op_reg;
    logic signed [OW-1:0]        ar_reg, ai_reg, br_reg, bi_reg;
    logic [2:0]                  k_reg;
    logic                        pvalid_reg;
    logic [DW-1:0]               prod_reg;
    logic                        psub_reg;
    dst_t                        pdst_reg;
    logic [DW-1:0]               acc_r_reg, acc_i_reg, den_reg;
    logic                        div_idx_reg;
    logic                        div_run_reg;
    logic                        div_neg_reg;
    logic [31:0]                 x_reg, root_reg, bit_reg;
    logic                        small_reg;
    fpca_pkg::out_item_t         out_reg;

    step_t                       step;
    logic [2:0]                  n_prod;
    logic [OW-1:0]               opx, opy, magx, magy;
    logic [DW-1:0]               shifted, term;
    logic [DW-1:0]               num, num_mag, tval, t_mag, den_fix, d_mag;
    logic                        div_neg;
    logic                        div_start;
    logic                        div_done;
    logic [DW-1:0]               div_q;
    logic [31:0]                 trial;
    logic                        cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == fpca_pkg::REG_FRAC_BITS) ? {27'd0, frac_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= fpca_pkg::FracReset;
        end
        else if (cfg_write && paddr[2] == fpca_pkg::REG_FRAC_BITS)
        begin
            frac_reg <= pwdata[fpca_pkg::FracW-1:0];
        end
    end

    // Product schedule for each operation
    always_comb
    begin
        step   = '{x: SRC_AR, y: SRC_BR, dst: DST_R, neg: 1'b0};
        n_prod = 3'd0;
        case (op_reg)
            fpca_pkg::OP_MUL:
            begin
                n_prod = 3'd4;
                case (k_reg)
                    3'd0:    step = '{x: SRC_AR, y: SRC_BR, dst: DST_R, neg: 1'b0};
                    3'd1:    step = '{x: SRC_AI, y: SRC_BI, dst: DST_R, neg: 1'b1};
                    3'd2:    step = '{x: SRC_AR, y: SRC_BI, dst: DST_I, neg: 1'b0};
                    default: step = '{x: SRC_AI, y: SRC_BR, dst: DST_I, neg: 1'b0};
                endcase
            end
            fpca_pkg::OP_DIV:
            begin
                n_prod = 3'd6;
                case (k_reg)
                    3'd0:    step = '{x: SRC_AR, y: SRC_BR, dst: DST_R, neg: 1'b0};
                    3'd1:    step = '{x: SRC_AI, y: SRC_BI, dst: DST_R, neg: 1'b0};
                    3'd2:    step = '{x: SRC_AR, y: SRC_BI, dst: DST_I, neg: 1'b1};
                    3'd3:    step = '{x: SRC_AI, y: SRC_BR, dst: DST_I, neg: 1'b0};
                    3'd4:    step = '{x: SRC_BR, y: SRC_BR, dst: DST_D, neg: 1'b0};
                    default: step = '{x: SRC_BI, y: SRC_BI, dst: DST_D, neg: 1'b0};
                endcase
            end
            fpca_pkg::OP_MAG:
            begin
                n_prod = 3'd2;
                case (k_reg)
                    3'd0:    step = '{x: SRC_AR, y: SRC_AR, dst: DST_R, neg: 1'b0};
                    default: step = '{x: SRC_AI, y: SRC_AI, dst: DST_R, neg: 1'b0};
                endcase
            end
            default:
            begin
                n_prod = 3'd0;
            end
        endcase
    end

    // Operand selection and magnitudes for the shared multiplier
    always_comb
    begin
        case (step.x)
            SRC_AR:  opx = ar_reg;
            SRC_AI:  opx = ai_reg;
            SRC_BR:  opx = br_reg;
            default: opx = bi_reg;
        endcase
        case (step.y)
            SRC_AR:  opy = ar_reg;
            SRC_AI:  opy = ai_reg;
            SRC_BR:  opy = br_reg;
            default: opy = bi_reg;
        endcase
        magx = opx[OW-1] ? (~opx + 1'b1) : opx;
        magy = opy[OW-1] ? (~opy + 1'b1) : opy;
    end

    // Scale the registered product and apply its sign
    always_comb
    begin
        shifted = prod_reg >> frac_reg;
        term    = psub_reg ? (~shifted + 1'b1) : shifted;
    end

    // Operands of the divider: magnitudes of the pre-shifted numerator and of the divisor
    always_comb
    begin
        num     = div_idx_reg ? acc_i_reg : acc_r_reg;
        num_mag = num[DW-1] ? (~num + 1'b1) : num;
        tval    = num_mag << frac_reg;
        t_mag   = tval[DW-1] ? (~tval + 1'b1) : tval;
        den_fix = (den_reg == '0) ? DW'(1) : den_reg;
        d_mag   = den_fix[DW-1] ? (~den_fix + 1'b1) : den_fix;
        div_neg = tval[DW-1] ^ den_fix[DW-1] ^ num[DW-1];
    end

    assign div_start = (state_reg == S_DIV) && !div_run_reg;

    fpca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (t_mag),
        .divisor  (d_mag),
        .done     (div_done),
        .quotient (div_q)
    );

    // Square root trial value
    assign trial = root_reg + bit_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            pvalid_reg  <= 1'b0;
            div_idx_reg <= 1'b0;
            div_run_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        k_reg       <= '0;
                        pvalid_reg  <= 1'b0;
                        div_idx_reg <= 1'b0;
                        div_run_reg <= 1'b0;
                        if (in_data.operation == fpca_pkg::OP_MUL ||
                            in_data.operation == fpca_pkg::OP_DIV ||
                            in_data.operation == fpca_pkg::OP_MAG)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_MUL:
                begin
                    k_reg      <= k_reg + 1'b1;
                    pvalid_reg <= (k_reg < n_prod);
                    if (k_reg == n_prod + 3'd1)
                    begin
                        if (op_reg == fpca_pkg::OP_DIV)
                        begin
                            state_reg <= S_DIV;
                        end
                        else if (op_reg == fpca_pkg::OP_MAG)
                        begin
                            state_reg <= S_SQRT;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DIV:
                begin
                    if (!div_run_reg)
                    begin
                        div_run_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        div_run_reg <= 1'b0;
                        div_idx_reg <= 1'b1;
                        if (div_idx_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == 32'd0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_reg    <= in_data.operation;
                    ar_reg    <= in_data.a_real;
                    ai_reg    <= in_data.a_imag;
                    br_reg    <= in_data.b_real;
                    bi_reg    <= in_data.b_imag;
                    acc_r_reg <= '0;
                    acc_i_reg <= '0;
                    den_reg   <= '0;
                    out_reg   <= '0;
                    if (in_data.operation == fpca_pkg::OP_ADD)
                    begin
                        out_reg.res_real <= DW'(in_data.a_real) + DW'(in_data.b_real);
                        out_reg.res_imag <= DW'(in_data.a_imag) + DW'(in_data.b_imag);
                    end
                    else if (in_data.operation == fpca_pkg::OP_SUB)
                    begin
                        out_reg.res_real <= DW'(in_data.a_real) - DW'(in_data.b_real);
                        out_reg.res_imag <= DW'(in_data.a_imag) - DW'(in_data.b_imag);
                    end
                end
            end
            S_MUL:
            begin
                // Issue the next product
                prod_reg <= DW'(magx) * DW'(magy);
                psub_reg <= opx[OW-1] ^ opy[OW-1] ^ step.neg;
                pdst_reg <= step.dst;
                // Accumulate the previous one
                if (pvalid_reg)
                begin
                    case (pdst_reg)
                        DST_R:   acc_r_reg <= acc_r_reg + term;
                        DST_I:   acc_i_reg <= acc_i_reg + term;
                        default: den_reg   <= den_reg + term;
                    endcase
                end
                if (k_reg == n_prod + 3'd1)
                begin
                    if (op_reg == fpca_pkg::OP_MUL)
                    begin
                        out_reg.res_real <= acc_r_reg;
                        out_reg.res_imag <= acc_i_reg;
                    end
                    x_reg     <= acc_r_reg[32:1];
                    small_reg <= (acc_r_reg[32:1] <= 32'd1);
                    root_reg  <= '0;
                    bit_reg   <= 32'h4000_0000;
                end
            end
            S_DIV:
            begin
                if (!div_run_reg)
                begin
                    div_neg_reg <= div_neg;
                end
                else if (div_done)
                begin
                    if (div_idx_reg)
                    begin
                        out_reg.res_imag <= div_neg_reg ? (~div_q + 1'b1) : div_q;
                    end
                    else
                    begin
                        out_reg.res_real <= div_neg_reg ? (~div_q + 1'b1) : div_q;
                    end
                end
            end
            S_SQRT:
            begin
                if (bit_reg != 32'd0)
                begin
                    if (x_reg >= trial)
                    begin
                        x_reg    <= x_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                else
                begin
                    out_reg.magnitude <= small_reg ? '0 : root_reg[fpca_pkg::MagW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = out_reg;

endmodule
